### src/sem_pkg.sv
`default_nettype none

package sem_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_VOLT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;

  localparam logic [15:0] CUTOFF_VOLT_RST   = 16'd1300;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd250;
  localparam logic [15:0] FRAC_FULL         = 16'd32768;
  localparam logic [15:0] SILENCE_MAX       = 16'hFFFF;

  localparam int unsigned QUO_W = 15;
  localparam logic [3:0] DIV_LAST = 4'(QUO_W - 1);

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_CUT,
    ST_SQ_CAP,
    ST_SQ_IN,
    ST_DIFF,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } sem_state_t;

  typedef enum logic [1:0] {
    SQ_CUT,
    SQ_CAP,
    SQ_IN
  } sem_sq_sel_t;

  typedef struct packed {
    logic        load_frame;
    logic        tick;
    logic        sq_en;
    sem_sq_sel_t sq_sel;
    logic        diff_en;
    logic        div_init;
    logic        div_step;
    logic        div_last;
    logic        frac_zero;
    logic        frac_full;
    logic        out_load;
  } sem_cmd_t;

  typedef struct packed {
    logic num_pos;
    logic den_pos;
    logic num_ge_den;
  } sem_status_t;

  typedef struct packed {
    logic [15:0] input_volt_raw;
    logic [15:0] cap_volt_raw;
    logic [15:0] input_curr_raw;
    logic [15:0] target_power_raw;
  } sem_frame_t;

  typedef struct packed {
    logic        online;
    logic [15:0] percentage;
    logic [15:0] input_volt;
    logic [15:0] cap_volt;
    logic [15:0] input_curr;
    logic [15:0] target_power;
  } sem_result_t;

endpackage

`default_nettype wire

### src/sem_in_if.sv
`default_nettype none

interface sem_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] input_volt_raw;
  logic [15:0] cap_volt_raw;
  logic [15:0] input_curr_raw;
  logic [15:0] target_power_raw;

  modport source (
    output valid, opcode, input_volt_raw, cap_volt_raw, input_curr_raw, target_power_raw,
    input  ready
  );
  modport sink (
    input  valid, opcode, input_volt_raw, cap_volt_raw, input_curr_raw, target_power_raw,
    output ready
  );
endinterface

`default_nettype wire

### src/sem_out_if.sv
`default_nettype none

interface sem_out_if;
  logic        valid;
  logic        ready;
  logic        online;
  logic [15:0] percentage;
  logic [15:0] input_volt;
  logic [15:0] cap_volt;
  logic [15:0] input_curr;
  logic [15:0] target_power;

  modport source (
    output valid, online, percentage, input_volt, cap_volt, input_curr, target_power,
    input  ready
  );
  modport sink (
    input  valid, online, percentage, input_volt, cap_volt, input_curr, target_power,
    output ready
  );
endinterface

`default_nettype wire

### src/sem_cfg_if.sv
`default_nettype none

interface sem_cfg_if;
  import sem_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [15:0]          data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

### src/supercap_energy_monitor.sv
`default_nettype none

// Supercapacitor feedback monitor. Each input item is either a feedback frame
// or a tick, and each yields one result item carrying the link state, the held
// values and the stored-energy fraction in Q1.15. A frame passes through three
// squarings on one shared 16x16 multiplier, a subtract and a check stage, then
// a 15 step restoring divider; a frame whose fraction is zero or full skips the
// divider. A tick goes straight to the result. No new item is taken until the
// last has been handed to the output register, but a new item is taken while
// the last result still waits there; a finished item holds until that register
// is free. Configuration writes are always accepted.

module supercap_energy_monitor
  import sem_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  sem_in_if.sink    in_ch,
  sem_out_if.source out_ch,
  sem_cfg_if.sink   cfg_ch
);

  sem_cmd_t    cmd;
  sem_status_t status;
  sem_frame_t  frame;
  sem_result_t result;
  logic        in_ready;
  logic        out_valid;

  assign frame.input_volt_raw   = in_ch.input_volt_raw;
  assign frame.cap_volt_raw     = in_ch.cap_volt_raw;
  assign frame.input_curr_raw   = in_ch.input_curr_raw;
  assign frame.target_power_raw = in_ch.target_power_raw;

  assign cfg_ch.ready = 1'b1;

  sem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sem_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .frame     (frame),
    .cfg_we    (cfg_ch.valid),
    .cfg_idx   (cfg_ch.index),
    .cfg_wdata (cfg_ch.data),
    .result    (result)
  );

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.online       = result.online;
  assign out_ch.percentage   = result.percentage;
  assign out_ch.input_volt   = result.input_volt;
  assign out_ch.cap_volt     = result.cap_volt;
  assign out_ch.input_curr   = result.input_curr;
  assign out_ch.target_power = result.target_power;

endmodule

`default_nettype wire

### src/sem_datapath.sv
`default_nettype none

module sem_datapath
  import sem_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sem_cmd_t             cmd,
  output sem_status_t               status,
  input  wire sem_frame_t           frame,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [15:0]          cfg_wdata,
  output sem_result_t               result
);

  logic [15:0] cutoff_r, timeout_r;
  logic [15:0] vin_r, vcap_r, iin_r, ptgt_r;
  logic [15:0] frac_r, frac_nxt;
  logic        link_r;
  logic [15:0] silence_r, silence_nxt;
  logic [15:0] sq_op;
  logic [31:0] sq_prod;
  logic [31:0] cut2_r, cap2_r, in2_r;
  logic [32:0] num_r, den_r, num_nxt, den_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [QUO_W-2:0] quo_r;
  logic [32:0] rem_dbl, rem_sub;
  logic        fits;
  sem_result_t res_r;

  always_comb begin
    case (cmd.sq_sel)
      SQ_CUT:  sq_op = cutoff_r;
      SQ_CAP:  sq_op = vcap_r;
      SQ_IN:   sq_op = vin_r;
      default: sq_op = cutoff_r;
    endcase
    sq_prod = sq_op * sq_op;
  end

  assign num_nxt = {1'b0, cap2_r} - {1'b0, cut2_r};
  assign den_nxt = {1'b0, in2_r} - {1'b0, cut2_r};

  assign status.num_pos    = !num_r[32] && (|num_r[31:0]);
  assign status.den_pos    = !den_r[32] && (|den_r[31:0]);
  assign status.num_ge_den = num_r >= den_r;

  assign rem_dbl = {rem_r, 1'b0};
  assign fits    = rem_dbl >= den_r;
  assign rem_sub = rem_dbl - den_r;
  assign rem_nxt = fits ? rem_sub[31:0] : rem_dbl[31:0];

  assign silence_nxt = (silence_r == SILENCE_MAX) ? silence_r : silence_r + 16'd1;

  always_comb begin
    frac_nxt = frac_r;
    if (cmd.frac_zero) begin
      frac_nxt = '0;
    end else if (cmd.frac_full) begin
      frac_nxt = FRAC_FULL;
    end else if (cmd.div_step && cmd.div_last) begin
      frac_nxt = {1'b0, quo_r, fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r  <= CUTOFF_VOLT_RST;
      timeout_r <= TIMEOUT_TICKS_RST;
      vin_r     <= '0;
      vcap_r    <= '0;
      iin_r     <= '0;
      ptgt_r    <= '0;
      frac_r    <= '0;
      link_r    <= 1'b0;
      silence_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_CUTOFF_VOLT:   cutoff_r  <= cfg_wdata;
          REG_TIMEOUT_TICKS: timeout_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load_frame) begin
        vin_r     <= frame.input_volt_raw;
        vcap_r    <= frame.cap_volt_raw;
        iin_r     <= frame.input_curr_raw;
        ptgt_r    <= frame.target_power_raw;
        link_r    <= 1'b1;
        silence_r <= '0;
      end else if (cmd.tick) begin
        silence_r <= silence_nxt;
        if (silence_nxt > timeout_r) begin
          vin_r  <= '0;
          vcap_r <= '0;
          iin_r  <= '0;
          ptgt_r <= '0;
          link_r <= 1'b0;
        end
      end
      frac_r <= frac_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      case (cmd.sq_sel)
        SQ_CUT:  cut2_r <= sq_prod;
        SQ_CAP:  cap2_r <= sq_prod;
        SQ_IN:   in2_r  <= sq_prod;
        default: cut2_r <= sq_prod;
      endcase
    end
    if (cmd.diff_en) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
    if (cmd.div_init) begin
      rem_r <= num_r[31:0];
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QUO_W-3:0], fits};
    end
    if (cmd.out_load) begin
      res_r.online       <= link_r;
      res_r.percentage   <= frac_r;
      res_r.input_volt   <= vin_r;
      res_r.cap_volt     <= vcap_r;
      res_r.input_curr   <= iin_r;
      res_r.target_power <= ptgt_r;
    end
  end

  assign result = res_r;

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    frac_r <= FRAC_FULL)
    else $error("fraction above full scale");

  a_offline_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !link_r |-> (vin_r == '0 && vcap_r == '0 && iin_r == '0 && ptgt_r == '0))
    else $error("held values not cleared while offline");

  a_frame_online: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_frame |=> (link_r && silence_r == '0))
    else $error("frame did not bring link online");

endmodule

`default_nettype wire

### src/sem_ctrl.sv
`default_nettype none

module sem_ctrl
  import sem_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_opcode,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire sem_status_t status,
  output sem_cmd_t         cmd
);

  sem_state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_opcode == OP_FRAME) ? ST_SQ_CUT : ST_DONE;
        end
      end
      ST_SQ_CUT: state_nxt = ST_SQ_CAP;
      ST_SQ_CAP: state_nxt = ST_SQ_IN;
      ST_SQ_IN:  state_nxt = ST_DIFF;
      ST_DIFF:   state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (!status.num_pos || !status.den_pos || status.num_ge_den) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.sq_sel    = SQ_CUT;
    in_ready      = 1'b0;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_frame = in_valid && (in_opcode == OP_FRAME);
        cmd.tick       = in_valid && (in_opcode == OP_TICK);
      end
      ST_SQ_CUT: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = SQ_CUT;
      end
      ST_SQ_CAP: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = SQ_CAP;
      end
      ST_SQ_IN: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = SQ_IN;
      end
      ST_DIFF: cmd.diff_en = 1'b1;
      ST_CHECK: begin
        cnt_nxt = '0;
        if (!status.num_pos || !status.den_pos) begin
          cmd.frac_zero = 1'b1;
        end else if (status.num_ge_den) begin
          cmd.frac_full = 1'b1;
        end else begin
          cmd.div_init = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = (cnt_r == DIV_LAST);
        cnt_nxt      = cnt_r + 4'd1;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_frame_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_opcode == OP_FRAME) |=> state_r == ST_SQ_CUT)
    else $error("frame did not start squaring");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> cnt_r <= DIV_LAST)
    else $error("divider step count overrun");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_ready) |=> state_r == ST_DONE)
    else $error("result loaded over a waiting item");

endmodule

`default_nettype wire
